FILE: rtl/windowed_turbulence_intensity_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef WINDOWED_TURBULENCE_INTENSITY_DEFINES_SVH
`define WINDOWED_TURBULENCE_INTENSITY_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define WTI_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define WTI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/wti_pkg.sv
`timescale 1ns / 1ps

package wti_pkg;

  localparam int MaxWindowDef = 15;
  localparam int MaxGatesDef  = 1024;
  localparam int SizeW        = 4;
  localparam logic [SizeW-1:0] SizeReset = 4'd5;
  localparam int TiW          = 16;
  localparam int GateOutW     = 10;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_ZERO = 2'd2,
    ST_SAT  = 2'd3
  } wti_status_e;

  typedef enum logic [2:0] {
    E_IDLE, E_MUL1, E_MUL2, E_MUL3, E_CHK, E_DIV, E_SQRT, E_DONE
  } wti_eval_st_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_GATHER, S_START, S_EVAL, S_OUT
  } wti_seq_st_e;

  typedef struct packed {
    logic               vld;
    logic signed [15:0] val;
  } wti_entry_t;

  typedef struct packed {
    logic [TiW-1:0] ti;
    wti_status_e    status;
  } wti_res_t;

endpackage

FILE: rtl/wti_if.sv
`timescale 1ns / 1ps

interface wti_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_value;
  logic               sample_valid;
  logic               ray_end;

  modport source (output valid, sample_value, sample_valid, ray_end, input ready);
  modport sink   (input valid, sample_value, sample_valid, ray_end, output ready);
endinterface

interface wti_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] ti_value;
  logic [9:0]  result_gate;
  logic [1:0]  ti_status;
  logic        ray_last;

  modport source (output valid, ti_value, result_gate, ti_status, ray_last, input ready);
  modport sink   (input valid, ti_value, result_gate, ti_status, ray_last, output ready);
endinterface

FILE: rtl/wti_cell.sv
`timescale 1ns / 1ps

// One window slot: takes its neighbor's entry on every shift, or zero at ray start.
module wti_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                clear_i,
  input  wti_pkg::wti_entry_t entry_i,
  output wti_pkg::wti_entry_t entry_o
);
  import wti_pkg::*;

  wti_entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (shift_i) begin
      entry_d = clear_i ? '0 : entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
endmodule

FILE: rtl/wti_eval.sv
`timescale 1ns / 1ps

// Turns count, sum and square sum into floor(4096 * s / |m|) with a
// restoring divider and a digit-by-digit square root, one step per cycle.
module wti_eval #(
  parameter int  CntW = 4,
  localparam int AbsW = 15 + CntW,
  localparam int SumW = AbsW + 1,
  localparam int SqW  = 30 + CntW,
  localparam int S2W  = 2 * AbsW,
  localparam int NumW = CntW + S2W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [CntW-1:0]        cnt_i,
  input  logic signed [SumW-1:0] sum_i,
  input  logic [SqW-1:0]         sq_i,
  output logic                   done_o,
  output wti_pkg::wti_res_t      res_o
);
  import wti_pkg::*;

  wti_eval_st_e    st_q, st_d;
  logic [4:0]      it_q, it_d;
  logic [CntW-1:0] n_q, n_d;
  logic [AbsW-1:0] abs_q, abs_d;
  logic [SqW-1:0]  sq_q, sq_d;
  logic [S2W-1:0]  s2_q, s2_d, nq_q, nq_d, dif_q, dif_d;
  logic [NumW-1:0] num_q, num_d, den_q, den_d, rem_q, rem_d;
  logic [31:0]     quo_q, quo_d, x_q, x_d, r_q, r_d, b_q, b_d;
  wti_res_t        res_q, res_d;

  logic [NumW:0]   rem2;
  logic [7:0]      low_byte;
  logic            dbit, ge;
  logic [31:0]     trial, r_nxt;

  always_comb begin
    st_d  = st_q;
    it_d  = it_q;
    n_d   = n_q;
    abs_d = abs_q;
    sq_d  = sq_q;
    s2_d  = s2_q;
    nq_d  = nq_q;
    dif_d = dif_q;
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    quo_d = quo_q;
    x_d   = x_q;
    r_d   = r_q;
    b_d   = b_q;
    res_d = res_q;
    low_byte = num_q[7:0];
    dbit  = (it_q[4:3] == 2'b11) ? low_byte[it_q[2:0]] : 1'b0;
    rem2  = {rem_q, dbit};
    ge    = (rem2 >= {1'b0, den_q});
    trial = r_q + b_q;
    r_nxt = (x_q >= trial) ? ((r_q >> 1) + b_q) : (r_q >> 1);
    case (st_q)
      E_IDLE: begin
        if (start_i) begin
          n_d   = cnt_i;
          sq_d  = sq_i;
          abs_d = sum_i[SumW-1] ? AbsW'(-sum_i) : AbsW'(sum_i);
          if (cnt_i < CntW'(2)) begin
            res_d = '{ti: '0, status: ST_FEW};
            st_d  = E_DONE;
          end else if (sum_i == '0) begin
            res_d = '{ti: '0, status: ST_ZERO};
            st_d  = E_DONE;
          end else begin
            st_d = E_MUL1;
          end
        end
      end
      E_MUL1: begin
        s2_d = abs_q * abs_q;
        nq_d = n_q * sq_q;
        st_d = E_MUL2;
      end
      E_MUL2: begin
        dif_d = nq_q - s2_q;
        st_d  = E_MUL3;
      end
      E_MUL3: begin
        num_d = n_q * dif_q;
        den_d = (n_q - CntW'(1)) * s2_q;
        st_d  = E_CHK;
      end
      E_CHK: begin
        if ({8'b0, num_q} >= {den_q, 8'b0}) begin
          res_d = '{ti: '1, status: ST_SAT};
          st_d  = E_DONE;
        end else begin
          rem_d = num_q >> 8;
          quo_d = '0;
          it_d  = 5'd31;
          st_d  = E_DIV;
        end
      end
      E_DIV: begin
        rem_d = ge ? NumW'(rem2 - {1'b0, den_q}) : NumW'(rem2);
        quo_d = {quo_q[30:0], ge};
        if (it_q == '0) begin
          x_d  = {quo_q[30:0], ge};
          r_d  = '0;
          b_d  = 32'h4000_0000;
          it_d = 5'd15;
          st_d = E_SQRT;
        end else begin
          it_d = it_q - 5'd1;
        end
      end
      E_SQRT: begin
        if (x_q >= trial) begin
          x_d = x_q - trial;
        end
        r_d = r_nxt;
        b_d = b_q >> 2;
        if (it_q == '0) begin
          res_d = '{ti: r_nxt[15:0], status: ST_OK};
          st_d  = E_DONE;
        end else begin
          it_d = it_q - 5'd1;
        end
      end
      E_DONE: st_d = E_IDLE;
      default: st_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= E_IDLE;
      it_q <= '0;
    end else begin
      st_q <= st_d;
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    abs_q <= abs_d;
    sq_q  <= sq_d;
    s2_q  <= s2_d;
    nq_q  <= nq_d;
    dif_q <= dif_d;
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    x_q   <= x_d;
    r_q   <= r_d;
    b_q   <= b_d;
    res_q <= res_d;
  end

  assign done_o = (st_q == E_DONE);
  assign res_o  = res_q;
endmodule

FILE: rtl/windowed_turbulence_intensity.sv
`timescale 1ns / 1ps
// Sequential block: one input transaction at a time. For each result the sequencer runs setup,
// walks the window, starts the evaluator (4 multiply and check, 32 divider and 16 square-root
// steps, then done, where not cut short) and loads the result into the output register, which
// can wait for the sink. A gate with no result leaves the sequencer idle; otherwise the next
// transaction is taken once the last result is registered. The last gate of a ray flushes up
// to h + 1 results, h being the half width.
// Reset (asynchronous, active low) clears the window cells, gate counter and handshakes.

// The samples of a ray shift through a row of cells, newest in cell 0. For every
// result gate g the sequencer walks the cells that cover gates g-h .. g+h (cut off at
// the ray ends), accumulating count, sum and sum of squares one cell per cycle. The
// evaluator then forms n*(n*Q - S^2) / ((n-1)*S^2), scales it by 2^24, and takes an
// integer square root, which is floor(4096 * stddev / |mean|). Results go into an
// output register so the next input transaction can be taken while the final result
// of a gate still waits for the sink.
module windowed_turbulence_intensity #(
  parameter int MAX_WINDOW = wti_pkg::MaxWindowDef,
  parameter int MAX_GATES  = wti_pkg::MaxGatesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [wti_pkg::SizeW-1:0] cfg_wdata_i,
  wti_in_if.sink                   smp_i,
  wti_out_if.source                res_o
);
  import wti_pkg::*;

  localparam int CntW = $clog2(MAX_WINDOW + 1);
  localparam int AbsW = 15 + CntW;
  localparam int SumW = AbsW + 1;
  localparam int SqW  = 30 + CntW;
  localparam int GW   = $clog2(MAX_GATES);
  localparam int HMax = (MAX_WINDOW - 1) / 2;
  localparam int HW   = (HMax > 0) ? $clog2(HMax + 1) : 1;
  localparam int KW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  // Window size register; the half width is latched at the first gate of a ray.
  logic [SizeW-1:0] wsize_q;
  logic [HW-1:0]    h_q, h_d, h_cfg, h_new;

  wti_seq_st_e      st_q, st_d;
  logic [GW-1:0]    gpos_q, gpos_d, p_q, p_d, g_q, g_d, gend_q, gend_d;
  logic [GW-1:0]    i_q, i_d, hi_q, hi_d;
  logic             end_q, end_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SqW-1:0]   sq_q, sq_d;
  wti_res_t         eres_q, eres_d;

  logic             ovalid_q, ovalid_d;
  logic [TiW-1:0]   oti_q, oti_d;
  logic [GateOutW-1:0] ogate_q, ogate_d;
  wti_status_e      ostat_q, ostat_d;
  logic             olast_q, olast_d;

  logic             accept, end_w, load;
  logic [GW-1:0]    lo, hi, k;
  logic [GW:0]      g_plus_h;
  logic signed [31:0] prod;
  wti_entry_t       rd;
  logic             ev_done;
  wti_res_t         ev_res;

  // Row of window cells.
  wti_entry_t cell_q [MAX_WINDOW];
  wti_entry_t new_entry;

  assign new_entry = '{vld: smp_i.sample_valid, val: smp_i.sample_value};

  for (genvar c = 0; c < MAX_WINDOW; c++) begin : g_cell
    if (c == 0) begin : g_head
      wti_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept),
        .clear_i (1'b0),
        .entry_i (new_entry),
        .entry_o (cell_q[c])
      );
    end else begin : g_body
      wti_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (accept),
        .clear_i (gpos_q == '0),
        .entry_i (cell_q[c-1]),
        .entry_o (cell_q[c])
      );
    end
  end

  wti_eval #(.CntW(CntW)) u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (st_q == S_START),
    .cnt_i   (cnt_q),
    .sum_i   (sum_q),
    .sq_i    (sq_q),
    .done_o  (ev_done),
    .res_o   (ev_res)
  );

  assign smp_i.ready = (st_q == S_IDLE);
  assign accept      = smp_i.valid && smp_i.ready;
  assign h_cfg       = (int'(wsize_q >> 1) > HMax) ? HW'(HMax) : HW'(wsize_q >> 1);
  assign h_new       = (gpos_q == '0) ? h_cfg : h_q;
  assign end_w       = smp_i.ray_end || (gpos_q == GW'(MAX_GATES - 1));

  // Window bounds of the current result gate, clipped to the ray.
  assign lo       = (g_q >= GW'(h_q)) ? (g_q - GW'(h_q)) : '0;
  assign g_plus_h = {1'b0, g_q} + (GW+1)'(h_q);
  assign hi       = (g_plus_h < {1'b0, p_q}) ? GW'(g_plus_h) : p_q;

  // Cell k holds gate p - k.
  assign k    = p_q - i_q;
  assign rd   = cell_q[k[KW-1:0]];
  assign prod = rd.val * rd.val;
  assign load = !ovalid_q || res_o.ready;

  always_comb begin
    st_d    = st_q;
    gpos_d  = gpos_q;
    h_d     = h_q;
    p_d     = p_q;
    g_d     = g_q;
    gend_d  = gend_q;
    end_d   = end_q;
    i_d     = i_q;
    hi_d    = hi_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    eres_d  = eres_q;
    ovalid_d = ovalid_q && !res_o.ready;
    oti_d   = oti_q;
    ogate_d = ogate_q;
    ostat_d = ostat_q;
    olast_d = olast_q;
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          h_d    = h_new;
          p_d    = gpos_q;
          end_d  = end_w;
          gpos_d = end_w ? '0 : gpos_q + GW'(1);
          g_d    = (gpos_q >= GW'(h_new)) ? (gpos_q - GW'(h_new)) : '0;
          gend_d = end_w ? gpos_q : (gpos_q - GW'(h_new));
          if ((gpos_q >= GW'(h_new)) || end_w) begin
            st_d = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        i_d   = lo;
        hi_d  = hi;
        cnt_d = '0;
        sum_d = '0;
        sq_d  = '0;
        st_d  = S_GATHER;
      end
      S_GATHER: begin
        if (rd.vld) begin
          cnt_d = cnt_q + CntW'(1);
          sum_d = sum_q + SumW'(rd.val);
          sq_d  = sq_q + SqW'(unsigned'(prod));
        end
        if (i_q == hi_q) begin
          st_d = S_START;
        end else begin
          i_d = i_q + GW'(1);
        end
      end
      S_START: st_d = S_EVAL;
      S_EVAL: begin
        if (ev_done) begin
          eres_d = ev_res;
          st_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (load) begin
          ovalid_d = 1'b1;
          oti_d    = eres_q.ti;
          ogate_d  = GateOutW'(g_q);
          ostat_d  = eres_q.status;
          olast_d  = end_q && (g_q == p_q);
          if (g_q == gend_q) begin
            st_d = S_IDLE;
          end else begin
            g_d  = g_q + GW'(1);
            st_d = S_SETUP;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q  <= SizeReset;
      st_q     <= S_IDLE;
      gpos_q   <= '0;
      h_q      <= HW'(2 > HMax ? HMax : 2);
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wsize_q <= cfg_wdata_i;
      end
      st_q     <= st_d;
      gpos_q   <= gpos_d;
      h_q      <= h_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    g_q     <= g_d;
    gend_q  <= gend_d;
    end_q   <= end_d;
    i_q     <= i_d;
    hi_q    <= hi_d;
    cnt_q   <= cnt_d;
    sum_q   <= sum_d;
    sq_q    <= sq_d;
    eres_q  <= eres_d;
    oti_q   <= oti_d;
    ogate_q <= ogate_d;
    ostat_q <= ostat_d;
    olast_q <= olast_d;
  end

  assign res_o.valid       = ovalid_q;
  assign res_o.ti_value    = oti_q;
  assign res_o.result_gate = ogate_q;
  assign res_o.ti_status   = ostat_q;
  assign res_o.ray_last    = olast_q;
endmodule

FILE: rtl/wti_chk.sv
`timescale 1ns / 1ps
`include "windowed_turbulence_intensity_defines.svh"

// Port-level checks on the result channel.
module wti_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] ti_value_i,
  input logic [1:0]  ti_status_i
);
  import wti_pkg::*;

  `WTI_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `WTI_ASSERT_NEXT(a_hold_value, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(ti_value_i))
  `WTI_ASSERT_NOW(a_zero_on_special, clk_i, rst_ni, out_valid_i && (ti_status_i == ST_FEW || ti_status_i == ST_ZERO), ti_value_i == '0)
  `WTI_ASSERT_NOW(a_sat_is_max, clk_i, rst_ni, out_valid_i && ti_status_i == ST_SAT, ti_value_i == 16'hFFFF)
endmodule

bind windowed_turbulence_intensity wti_chk u_wti_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .ti_value_i  (res_o.ti_value),
  .ti_status_i (res_o.ti_status)
);
